FILE: hw/rtl/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter pipeline.
// Depends on nothing; every other file of the block imports it.
package rhc_pkg;

   localparam int CH_W      = 8;
   localparam int HUE_W     = 15;
   localparam int HUE_QUO_W = 12;   // hue quotient is at most one sixth, 3840
   localparam int SAT_QUO_W = 8;    // saturation quotient is at most 255
   localparam int HUE_NUM_W = CH_W + HUE_QUO_W;
   localparam int SAT_NUM_W = CH_W + SAT_QUO_W;

   localparam int HUE_SIXTH    = 3840;   // 60 degrees in 1/64 degree units
   localparam int HUE_SECTOR_G = 7680;
   localparam int HUE_SECTOR_B = 15360;
   localparam int HUE_FULL     = 23040;  // 360 degrees
   localparam int SAT_SCALE    = 255;

   // Divider stage split: hue quotient bits and saturation quotient bits per stage.
   localparam int DIV1_HUE_STEPS = 4;
   localparam int DIV1_SAT_STEPS = 3;
   localparam int DIV2_HUE_STEPS = 4;
   localparam int DIV2_SAT_STEPS = 3;
   localparam int DIV3_HUE_STEPS = 4;
   localparam int DIV3_SAT_STEPS = 2;

   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic             hue_defined;
      logic [CH_W-1:0]  saturation;
      logic [CH_W-1:0]  brightness;
   } hsv_type;

   // Item in flight between the front stage and the back stage.
   typedef struct packed {
      logic                 defined;
      logic                 neg;
      logic [1:0]           sector;
      logic [CH_W-1:0]      chroma;
      logic [CH_W-1:0]      value;
      logic [CH_W-1:0]      hue_rem;
      logic [HUE_QUO_W-1:0] hue_num;
      logic [HUE_QUO_W-1:0] hue_quo;
      logic [CH_W-1:0]      sat_rem;
      logic [SAT_QUO_W-1:0] sat_num;
      logic [SAT_QUO_W-1:0] sat_quo;
   } work_type;

endpackage

FILE: hw/rtl/rhc_front.sv
// Front stage: max, min, chroma, hue sector and the two dividends.
// Depends on rhc_pkg.
module rhc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  rhc_pkg::pixel_type  up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output rhc_pkg::work_type   dn_data
);
   import rhc_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   work_type        data_ff;
   work_type        data_in;
   logic            load;
   logic [CH_W-1:0] hi;
   logic [CH_W-1:0] lo;
   logic [CH_W:0]   diff;
   logic [CH_W-1:0] mag;
   logic [HUE_NUM_W-1:0] hue_num;
   logic [SAT_NUM_W-1:0] sat_num;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      hi = up_data.red;
      lo = up_data.red;
      if (up_data.green > hi) hi = up_data.green;
      if (up_data.blue > hi) hi = up_data.blue;
      if (up_data.green < lo) lo = up_data.green;
      if (up_data.blue < lo) lo = up_data.blue;

      data_in         = '0;
      data_in.value   = hi;
      data_in.chroma  = hi - lo;
      data_in.defined = (hi != lo);

      // Red wins ties over green, green over blue.
      if (up_data.red == hi) begin
         data_in.sector = SECTOR_RED;
         diff = {1'b0, up_data.green} - {1'b0, up_data.blue};
      end else if (up_data.green == hi) begin
         data_in.sector = SECTOR_GREEN;
         diff = {1'b0, up_data.blue} - {1'b0, up_data.red};
      end else begin
         data_in.sector = SECTOR_BLUE;
         diff = {1'b0, up_data.red} - {1'b0, up_data.green};
      end

      data_in.neg = diff[CH_W];
      mag         = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];

      // Constant scaling; the high byte seeds the remainder.
      hue_num = HUE_NUM_W'(mag) * HUE_NUM_W'(HUE_SIXTH);
      sat_num = SAT_NUM_W'(data_in.chroma) * SAT_NUM_W'(SAT_SCALE);

      data_in.hue_rem = hue_num[HUE_NUM_W-1 -: CH_W];
      data_in.hue_num = hue_num[HUE_QUO_W-1:0];
      data_in.sat_rem = sat_num[SAT_NUM_W-1 -: CH_W];
      data_in.sat_num = sat_num[SAT_QUO_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

FILE: hw/rtl/rhc_div_stage.sv
// One stage of the two pipelined restoring dividers (hue and saturation).
// Depends on rhc_pkg.
module rhc_div_stage #(
   parameter int HUE_STEPS = rhc_pkg::DIV1_HUE_STEPS,
   parameter int SAT_STEPS = rhc_pkg::DIV1_SAT_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  rhc_pkg::work_type  up_data,
   output logic               dn_valid,
   input  logic               dn_ready,
   output rhc_pkg::work_type  dn_data
);
   import rhc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   work_type data_ff;
   work_type data_in;
   logic     load;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      logic [CH_W:0] trial_h;
      logic [CH_W:0] trial_s;
      logic          bit_h;
      logic          bit_s;

      data_in = up_data;
      // Bring down one dividend bit, subtract the divisor when it fits.
      for (int i = 0; i < HUE_STEPS; i++) begin
         trial_h = {data_in.hue_rem, data_in.hue_num[HUE_QUO_W-1]};
         bit_h   = (trial_h >= {1'b0, data_in.chroma});
         if (bit_h) begin
            data_in.hue_rem = CH_W'(trial_h - {1'b0, data_in.chroma});
         end else begin
            data_in.hue_rem = trial_h[CH_W-1:0];
         end
         data_in.hue_num = {data_in.hue_num[HUE_QUO_W-2:0], 1'b0};
         data_in.hue_quo = {data_in.hue_quo[HUE_QUO_W-2:0], bit_h};
      end
      for (int i = 0; i < SAT_STEPS; i++) begin
         trial_s = {data_in.sat_rem, data_in.sat_num[SAT_QUO_W-1]};
         bit_s   = (trial_s >= {1'b0, data_in.value});
         if (bit_s) begin
            data_in.sat_rem = CH_W'(trial_s - {1'b0, data_in.value});
         end else begin
            data_in.sat_rem = trial_s[CH_W-1:0];
         end
         data_in.sat_num = {data_in.sat_num[SAT_QUO_W-2:0], 1'b0};
         data_in.sat_quo = {data_in.sat_quo[SAT_QUO_W-2:0], bit_s};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

FILE: hw/rtl/rhc_back.sv
// Back stage: sign and sector offset on the hue, grey override, output register.
// Depends on rhc_pkg.
module rhc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  rhc_pkg::work_type  up_data,
   output logic               dn_valid,
   input  logic               dn_ready,
   output rhc_pkg::hsv_type   dn_data
);
   import rhc_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   hsv_type          data_ff;
   hsv_type          data_in;
   logic             load;
   logic [HUE_W-1:0] base;
   logic [HUE_W-1:0] quo;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      case (up_data.sector)
         SECTOR_GREEN: base = HUE_W'(HUE_SECTOR_G);
         SECTOR_BLUE:  base = HUE_W'(HUE_SECTOR_B);
         default:      base = up_data.neg ? HUE_W'(HUE_FULL) : '0;
      endcase
      // A negative difference always gives a nonzero quotient, so wrap in the red
      // sector by starting from a full turn.
      quo = HUE_W'(up_data.hue_quo);

      data_in.brightness = up_data.value;
      data_in.hue_defined = up_data.defined;
      if (up_data.defined) begin
         data_in.hue        = up_data.neg ? HUE_W'(base - quo) : HUE_W'(base + quo);
         data_in.saturation = up_data.sat_quo;
      end else begin
         data_in.hue        = '0;
         data_in.saturation = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

FILE: hw/rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter, top level. Instantiates rhc_front, three rhc_div_stage
// and rhc_back; depends on rhc_pkg.
//
// Usage:
//   - Input channel req_valid/req_ready/req_data carries one pixel of 8-bit red,
//     green and blue per transfer.
//   - Result channel rsp_valid/rsp_ready/rsp_data carries hue (1/64 degree),
//     hue_defined, saturation (0..255) and brightness (largest channel).
//   - Five register stages: rhc_front, three rhc_div_stage and rhc_back.
//   - Throughput: one pixel per cycle unless the receiver stalls. The depth
//     is set by the two restoring dividers (12 hue quotient bits, 8 saturation
//     bits) spread over three stages, framed by a compare stage in front and
//     a fixup stage behind.
//   - Each stage holds its own valid bit. When the receiver stalls, a full
//     stage holds; empty stages upstream keep filling, so bubbles close up and
//     req_ready drops only once every stage is occupied. Nothing is dropped or
//     repeated.
//   - Grey pixels (all channels equal) give hue_defined low, hue 0, saturation 0.
//   - Synchronous reset empties the pipeline; no payload is cleared.
module rgb_to_hsv_converter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rhc_pkg::pixel_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rhc_pkg::hsv_type   rsp_data
);
   import rhc_pkg::*;

   // Stage links: front -> div1 -> div2 -> div3 -> back.
   logic     s1_valid, s1_ready;
   logic     s2_valid, s2_ready;
   logic     s3_valid, s3_ready;
   logic     s4_valid, s4_ready;
   work_type s1_data, s2_data, s3_data, s4_data;

   // Compare channels, pick the sector, form both dividends.
   rhc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_data  (req_data),
      .dn_valid (s1_valid),
      .dn_ready (s1_ready),
      .dn_data  (s1_data)
   );

   // Advance the quotients a few bits per stage.
   rhc_div_stage #(
      .HUE_STEPS (DIV1_HUE_STEPS),
      .SAT_STEPS (DIV1_SAT_STEPS)
   ) u_div1 (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s1_valid),
      .up_ready (s1_ready),
      .up_data  (s1_data),
      .dn_valid (s2_valid),
      .dn_ready (s2_ready),
      .dn_data  (s2_data)
   );

   rhc_div_stage #(
      .HUE_STEPS (DIV2_HUE_STEPS),
      .SAT_STEPS (DIV2_SAT_STEPS)
   ) u_div2 (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s2_valid),
      .up_ready (s2_ready),
      .up_data  (s2_data),
      .dn_valid (s3_valid),
      .dn_ready (s3_ready),
      .dn_data  (s3_data)
   );

   rhc_div_stage #(
      .HUE_STEPS (DIV3_HUE_STEPS),
      .SAT_STEPS (DIV3_SAT_STEPS)
   ) u_div3 (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s3_valid),
      .up_ready (s3_ready),
      .up_data  (s3_data),
      .dn_valid (s4_valid),
      .dn_ready (s4_ready),
      .dn_data  (s4_data)
   );

   // Apply sign and sector offset, override grey pixels, hold the result.
   rhc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s4_valid),
      .up_ready (s4_ready),
      .up_data  (s4_data),
      .dn_valid (rsp_valid),
      .dn_ready (rsp_ready),
      .dn_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // An empty output register means no stage can be blocked.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output register is empty");

   // Hue stays inside one turn.
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hue < HUE_W'(HUE_FULL)))
      else $error("hue out of range");

   // Grey pixels carry zero hue and zero saturation.
   a_grey_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hue_defined) |->
         (rsp_data.hue == '0 && rsp_data.saturation == '0))
      else $error("grey pixel with nonzero hue or saturation");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
